@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define HD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define HD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define HD_ASSERT(lbl, clk, rst_n, prop)
`define HD_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ hdl/hd_pkg.sv @@
package hd_pkg;

  // Field widths.
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CNT_W  = 31;
  localparam int unsigned NODE_W = 40;
  localparam int unsigned ID_W   = 9;

  localparam int unsigned ALPHABET_SIZE_DEF = 256;
  localparam int unsigned LEAF_CNT          = 256;

  // Leaves are numbered in signed-byte order.
  localparam logic [SYM_W-1:0] LEAF_FLIP = 8'h80;
  localparam logic [2:0]       MSB_INDEX = 3'd7;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_INIT_END,
    S_PICK,
    S_PICK_END,
    S_MERGE,
    S_WALK_BIT,
    S_WALK_SEL,
    S_FLUSH
  } state_e;

  // Running minimum over the live leaves.
  typedef struct packed {
    logic             vld;
    logic [SYM_W-1:0] id;
    logic [CNT_W-1:0] w;
  } leaf_best_t;

endpackage

@@ hdl/hd_count_table.sv @@
module hd_count_table
  import hd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             wr_en_i,
  input  logic [SYM_W-1:0] wr_addr_i,
  input  logic [CNT_W-1:0] wr_data_i,
  input  logic [SYM_W-1:0] rd_addr_i,
  output logic [CNT_W-1:0] rd_data_o
);

  logic [CNT_W-1:0] mem_q [LEAF_CNT];
  logic [CNT_W-1:0] rd_q;
  logic [LEAF_CNT-1:0] vld_q;
  logic rd_vld_q;

  // Count storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // Valid bits make a cleared entry read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

@@ hdl/hd_min_unit.sv @@
module hd_min_unit
  import hd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             smp_vld_i,
  input  logic [SYM_W-1:0] smp_id_i,
  input  logic [CNT_W-1:0] smp_w_i,
  output leaf_best_t       best_o
);

  leaf_best_t best_q, best_d;

  // Strict compare keeps the lower node number on a tie.
  always_comb begin
    best_d = best_q;
    if (clr_i) begin
      best_d = '0;
    end else if (smp_vld_i && (!best_q.vld || (smp_w_i < best_q.w))) begin
      best_d.vld = 1'b1;
      best_d.id  = smp_id_i;
      best_d.w   = smp_w_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

@@ hdl/hd_node_store.sv @@
module hd_node_store
  import hd_pkg::*;
(
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [SYM_W-1:0]  wr_idx_i,
  input  logic [ID_W-1:0]   wr_left_i,
  input  logic [ID_W-1:0]   wr_right_i,
  input  logic [NODE_W-1:0] wr_weight_i,
  input  logic [SYM_W-1:0]  w_rd_idx_i,
  output logic [NODE_W-1:0] w_rd_o,
  input  logic              c_rd_en_i,
  input  logic [SYM_W-1:0]  c_rd_idx_i,
  output logic [ID_W-1:0]   left_rd_o,
  output logic [ID_W-1:0]   right_rd_o
);

  logic [NODE_W-1:0] weight_q [LEAF_CNT];
  logic [ID_W-1:0]   left_q   [LEAF_CNT];
  logic [ID_W-1:0]   right_q  [LEAF_CNT];
  logic [NODE_W-1:0] w_rd_q;
  logic [ID_W-1:0]   left_rd_q;
  logic [ID_W-1:0]   right_rd_q;

  // Internal node weights, read continuously at the queue head.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      weight_q[wr_idx_i] <= wr_weight_i;
    end
    w_rd_q <= weight_q[w_rd_idx_i];
  end

  // Child links, read once per tree step.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      left_q[wr_idx_i]  <= wr_left_i;
      right_q[wr_idx_i] <= wr_right_i;
    end
    if (c_rd_en_i) begin
      left_rd_q  <= left_q[c_rd_idx_i];
      right_rd_q <= right_q[c_rd_idx_i];
    end
  end

  assign w_rd_o     = w_rd_q;
  assign left_rd_o  = left_rd_q;
  assign right_rd_o = right_rd_q;

endmodule

@@ hdl/huffman_decoder.sv @@
// Huffman decoder for a byte alphabet. A count load, a clear and an unused
// function code each leave the decoder in S_IDLE. The first data byte after a
// load or a clear first builds the code tree: one sweep totals the counts,
// then every merge sweeps the 256 leaves twice through one shared minimum
// unit and writes one node. Each data byte then walks the tree, each tree
// step a child memory read, then a select; when the table holds a single
// symbol, every bit yields that symbol. The last symbol of the byte is handed
// over from S_FLUSH; a stalled output holds the walk. Decoded symbols leave
// one beat each, with last_of_run set on the final symbol produced from a
// data byte.
`include "assert_macros.svh"

module huffman_decoder
  import hd_pkg::*;
#(
  parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       func_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic [CNT_W-1:0] symbol_count_i,
  input  logic [SYM_W-1:0] data_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SYM_W-1:0] out_symbol_o,
  output logic             last_of_run_o
);

  state_e state_q, state_d;

  logic [8:0]        scan_q, scan_d;
  logic              rd_vld_q, rd_vld_d;
  logic [SYM_W-1:0]  rd_id_q, rd_id_d;
  logic [8:0]        live_q, live_d;
  logic [NODE_W-1:0] total_q, total_d;
  logic [SYM_W-1:0]  last_q, last_d;
  logic [SYM_W-1:0]  int_head_q, int_head_d;
  logic [SYM_W-1:0]  next_int_q, next_int_d;
  logic              pick_b_q, pick_b_d;
  logic [ID_W-1:0]   a_id_q, a_id_d, b_id_q, b_id_d;
  logic [NODE_W-1:0] a_w_q, a_w_d, b_w_q, b_w_d;
  logic [ID_W-1:0]   root_q, root_d;
  logic [ID_W-1:0]   walk_q, walk_d;
  logic [NODE_W-1:0] sym_left_q, sym_left_d;
  logic              built_q, built_d;
  logic [SYM_W-1:0]  data_q, data_d;
  logic [2:0]        bit_idx_q, bit_idx_d;
  logic              pend_vld_q, pend_vld_d;
  logic [SYM_W-1:0]  pend_sym_q, pend_sym_d;
  logic              out_valid_q, out_valid_d;
  logic [SYM_W-1:0]  out_sym_q, out_sym_d;
  logic              out_last_q, out_last_d;

  logic [LEAF_CNT-1:0] used_q;
  logic                used_clr;
  logic                used_set;
  logic [SYM_W-1:0]    used_id;

  logic              cnt_clr, cnt_wr;
  logic [SYM_W-1:0]  cnt_rd_addr;
  logic [CNT_W-1:0]  cnt_rd;
  logic              min_clr, min_smp;
  leaf_best_t        best;
  logic              node_wr, child_rd;
  logic [NODE_W-1:0] int_w_rd;
  logic [ID_W-1:0]   left_rd, right_rd;
  logic              int_av, take_int, slot_ok, cur_bit;
  logic [ID_W-1:0]   pick_id, sel_node;
  logic [NODE_W-1:0] pick_w;

  hd_count_table u_count (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (cnt_clr),
    .wr_en_i   (cnt_wr),
    .wr_addr_i (symbol_i),
    .wr_data_i (symbol_count_i),
    .rd_addr_i (cnt_rd_addr),
    .rd_data_o (cnt_rd)
  );

  hd_min_unit u_min (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (min_clr),
    .smp_vld_i (min_smp),
    .smp_id_i  (rd_id_q),
    .smp_w_i   (cnt_rd),
    .best_o    (best)
  );

  hd_node_store u_nodes (
    .clk_i       (clk_i),
    .wr_en_i     (node_wr),
    .wr_idx_i    (next_int_q),
    .wr_left_i   (a_id_q),
    .wr_right_i  (b_id_q),
    .wr_weight_i (a_w_q + b_w_q),
    .w_rd_idx_i  (int_head_q),
    .w_rd_o      (int_w_rd),
    .c_rd_en_i   (child_rd),
    .c_rd_idx_i  (walk_q[SYM_W-1:0]),
    .left_rd_o   (left_rd),
    .right_rd_o  (right_rd)
  );

  // Leaf scan address and the queue of internal nodes.
  assign cnt_rd_addr = scan_q[SYM_W-1:0] ^ LEAF_FLIP;
  assign min_smp     = (state_q == S_PICK) && rd_vld_q && (cnt_rd != '0) && !used_q[rd_id_q];
  assign int_av      = (int_head_q != next_int_q);
  assign take_int    = int_av && (!best.vld || (int_w_rd < NODE_W'(best.w)));
  assign pick_id     = take_int ? {1'b1, int_head_q} : {1'b0, best.id};
  assign pick_w      = take_int ? int_w_rd : NODE_W'(best.w);
  assign cur_bit     = data_q[bit_idx_q];
  assign sel_node    = cur_bit ? right_rd : left_rd;
  assign slot_ok     = !pend_vld_q || !out_valid_q || out_ready_i;

  // Sequencer: next state and datapath control.
  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    rd_vld_d    = 1'b0;
    rd_id_d     = rd_id_q;
    live_d      = live_q;
    total_d     = total_q;
    last_d      = last_q;
    int_head_d  = int_head_q;
    next_int_d  = next_int_q;
    pick_b_d    = pick_b_q;
    a_id_d      = a_id_q;
    a_w_d       = a_w_q;
    b_id_d      = b_id_q;
    b_w_d       = b_w_q;
    root_d      = root_q;
    walk_d      = walk_q;
    sym_left_d  = sym_left_q;
    built_d     = built_q;
    data_d      = data_q;
    bit_idx_d   = bit_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_sym_d  = pend_sym_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    in_ready_o  = 1'b0;
    cnt_clr     = 1'b0;
    cnt_wr      = 1'b0;
    min_clr     = 1'b0;
    node_wr     = 1'b0;
    child_rd    = 1'b0;
    used_clr    = 1'b0;
    used_set    = 1'b0;
    used_id     = best.id;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (func_i)
            FUNC_LOAD: begin
              if ({1'b0, symbol_i} < 9'(ALPHABET_SIZE)) begin
                cnt_wr  = 1'b1;
                built_d = 1'b0;
              end
            end
            FUNC_CLEAR: begin
              cnt_clr    = 1'b1;
              built_d    = 1'b0;
              sym_left_d = '0;
              walk_d     = root_q;
            end
            FUNC_DATA: begin
              data_d    = data_byte_i;
              bit_idx_d = MSB_INDEX;
              if (built_q) begin
                state_d = S_WALK_BIT;
              end else begin
                scan_d   = '0;
                used_clr = 1'b1;
                live_d   = '0;
                total_d  = '0;
                last_d   = '0;
                state_d  = S_INIT;
              end
            end
            default: ;
          endcase
        end
      end

      S_INIT: begin
        if (!scan_q[8]) begin
          rd_vld_d = 1'b1;
          rd_id_d  = scan_q[SYM_W-1:0];
          scan_d   = scan_q + 9'd1;
        end else begin
          state_d = S_INIT_END;
        end
        if (rd_vld_q && (cnt_rd != '0)) begin
          live_d  = live_q + 9'd1;
          total_d = total_q + NODE_W'(cnt_rd);
          last_d  = rd_id_q;
        end
      end

      S_INIT_END: begin
        sym_left_d = total_q;
        int_head_d = '0;
        next_int_d = '0;
        if (live_q <= 9'd1) begin
          root_d  = {1'b0, last_q};
          walk_d  = {1'b0, last_q};
          built_d = 1'b1;
          state_d = S_WALK_BIT;
        end else begin
          pick_b_d = 1'b0;
          scan_d   = '0;
          min_clr  = 1'b1;
          state_d  = S_PICK;
        end
      end

      S_PICK: begin
        if (!scan_q[8]) begin
          rd_vld_d = 1'b1;
          rd_id_d  = scan_q[SYM_W-1:0];
          scan_d   = scan_q + 9'd1;
        end else begin
          state_d = S_PICK_END;
        end
      end

      // Lightest of the best leaf and the head of the internal queue.
      S_PICK_END: begin
        if (take_int) begin
          int_head_d = int_head_q + 8'd1;
        end else begin
          used_set = 1'b1;
        end
        if (!pick_b_q) begin
          a_id_d   = pick_id;
          a_w_d    = pick_w;
          pick_b_d = 1'b1;
          scan_d   = '0;
          min_clr  = 1'b1;
          state_d  = S_PICK;
        end else begin
          b_id_d  = pick_id;
          b_w_d   = pick_w;
          state_d = S_MERGE;
        end
      end

      S_MERGE: begin
        node_wr    = 1'b1;
        next_int_d = next_int_q + 8'd1;
        live_d     = live_q - 9'd1;
        if (live_q == 9'd2) begin
          root_d  = {1'b1, next_int_q};
          walk_d  = {1'b1, next_int_q};
          built_d = 1'b1;
          state_d = S_WALK_BIT;
        end else begin
          pick_b_d = 1'b0;
          scan_d   = '0;
          min_clr  = 1'b1;
          state_d  = S_PICK;
        end
      end

      S_WALK_BIT: begin
        if (sym_left_q == '0) begin
          state_d = S_FLUSH;
        end else if (!root_q[8]) begin
          if (slot_ok) begin
            if (pend_vld_q) begin
              out_valid_d = 1'b1;
              out_sym_d   = pend_sym_q;
              out_last_d  = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_sym_d = root_q[SYM_W-1:0] ^ LEAF_FLIP;
            sym_left_d = sym_left_q - NODE_W'(1);
            walk_d     = root_q;
            if (bit_idx_q == '0) begin
              state_d = S_FLUSH;
            end else begin
              bit_idx_d = bit_idx_q - 3'd1;
            end
          end
        end else begin
          child_rd = 1'b1;
          state_d  = S_WALK_SEL;
        end
      end

      S_WALK_SEL: begin
        if (!sel_node[8]) begin
          if (slot_ok) begin
            if (pend_vld_q) begin
              out_valid_d = 1'b1;
              out_sym_d   = pend_sym_q;
              out_last_d  = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_sym_d = sel_node[SYM_W-1:0] ^ LEAF_FLIP;
            sym_left_d = sym_left_q - NODE_W'(1);
            walk_d     = root_q;
            state_d    = (bit_idx_q == '0) ? S_FLUSH : S_WALK_BIT;
            bit_idx_d  = bit_idx_q - 3'd1;
          end
        end else begin
          walk_d    = sel_node;
          state_d   = (bit_idx_q == '0) ? S_FLUSH : S_WALK_BIT;
          bit_idx_d = bit_idx_q - 3'd1;
        end
      end

      // Hand over the held symbol as the last of this byte.
      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_sym_d   = pend_sym_q;
          out_last_d  = 1'b1;
          pend_vld_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      live_q      <= '0;
      int_head_q  <= '0;
      next_int_q  <= '0;
      pick_b_q    <= 1'b0;
      root_q      <= '0;
      walk_q      <= '0;
      sym_left_q  <= '0;
      built_q     <= 1'b0;
      bit_idx_q   <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_vld_d;
      live_q      <= live_d;
      int_head_q  <= int_head_d;
      next_int_q  <= next_int_d;
      pick_b_q    <= pick_b_d;
      root_q      <= root_d;
      walk_q      <= walk_d;
      sym_left_q  <= sym_left_d;
      built_q     <= built_d;
      bit_idx_q   <= bit_idx_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_id_q    <= rd_id_d;
    total_q    <= total_d;
    last_q     <= last_d;
    a_id_q     <= a_id_d;
    a_w_q      <= a_w_d;
    b_id_q     <= b_id_d;
    b_w_q      <= b_w_d;
    data_q     <= data_d;
    pend_sym_q <= pend_sym_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

  // Leaves already merged during the current build.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (used_clr) begin
      used_q <= '0;
    end else if (used_set) begin
      used_q[used_id] <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_symbol_o  = out_sym_q;
  assign last_of_run_o = out_last_q;

  `HD_ASSERT(a_queue_order, clk_i, rst_ni, int_head_q <= next_int_q)
  `HD_ASSERT(a_walk_built, clk_i, rst_ni, (state_q == S_WALK_BIT || state_q == S_WALK_SEL) |-> built_q)
  `HD_ASSERT(a_merge_live, clk_i, rst_ni, (state_q == S_MERGE) |-> (live_q >= 9'd2))
  `HD_ASSERT_NEVER(a_idle_pend, clk_i, rst_ni, (state_q == S_IDLE) && pend_vld_q)

endmodule
